// File: rtl/core/uvs_pkg.sv
// shared types, constants and rounding helpers for the uv sphere vertex generator
package uvs_pkg;

    // result kinds
    localparam logic [1:0] KIND_POS = 2'd0;
    localparam logic [1:0] KIND_NRM = 2'd1;
    localparam logic [1:0] KIND_TRI = 2'd2;
    localparam logic [1:0] KIND_ERR = 2'd3;

    // configuration register indexes
    localparam logic [1:0] REG_RADIUS  = 2'd0;
    localparam logic [1:0] REG_RINGS   = 2'd1;
    localparam logic [1:0] REG_SECTORS = 2'd2;

    // divider geometry
    localparam int DIV_NW       = 24;
    localparam int DIV_PER      = 4;
    localparam int DIV_STAGES   = DIV_NW / DIV_PER;
    localparam int DIV_RW       = 8;

    // cordic geometry
    localparam int CORDIC_STEPS = 16;
    localparam int CORDIC_PER   = 4;
    localparam int CORDIC_ITS   = CORDIC_STEPS / CORDIC_PER;
    localparam int CX_W         = 27;
    localparam int CZ_W         = 18;
    localparam logic signed [CX_W-1:0] CORDIC_K = 27'sd10188014;

    // pipeline stage indexes in the top level
    localparam int DIV_OUT_STAGE = DIV_STAGES;
    localparam int LAST_STAGE    = DIV_OUT_STAGE + CORDIC_ITS + 2 + 2;

    typedef struct packed {
        logic        err;
        logic        has_quad;
        logic [13:0] i00;
        logic [15:0] tu;
        logic [15:0] tv;
    } side_t;

    function automatic logic signed [CZ_W-1:0] atan_phase(input int i);
        logic signed [CZ_W-1:0] a;
        unique case (i)
            0:  a = 18'sd8192;
            1:  a = 18'sd4836;
            2:  a = 18'sd2555;
            3:  a = 18'sd1297;
            4:  a = 18'sd651;
            5:  a = 18'sd326;
            6:  a = 18'sd163;
            7:  a = 18'sd81;
            8:  a = 18'sd41;
            9:  a = 18'sd20;
            10: a = 18'sd10;
            11: a = 18'sd5;
            12: a = 18'sd3;
            13: a = 18'sd1;
            14: a = 18'sd1;
            default: a = 18'sd0;
        endcase
        return a;
    endfunction

    // round half away from zero, drop 14 fraction bits
    function automatic logic signed [33:0] rnd14(input logic signed [33:0] v);
        logic signed [33:0] r;
        if (v >= 0)
            r = (v + 34'sd8192) >>> 14;
        else
            r = -((-v + 34'sd8192) >>> 14);
        return r;
    endfunction

endpackage

// File: rtl/core/uvs_div.sv
// pipelined restoring divider, four quotient bits per stage
module uvs_div (
    input  logic                        clk,
    input  logic                        en,
    input  logic [uvs_pkg::DIV_NW-1:0]  num,
    input  logic [6:0]                  den,
    output logic [15:0]                 quo
);

    logic [uvs_pkg::DIV_NW-1:0] num_reg [0:uvs_pkg::DIV_STAGES-1];
    logic [uvs_pkg::DIV_NW-1:0] q_reg   [0:uvs_pkg::DIV_STAGES-1];
    logic [uvs_pkg::DIV_RW-1:0] rem_reg [0:uvs_pkg::DIV_STAGES-1];
    logic [6:0]                 den_reg [0:uvs_pkg::DIV_STAGES-1];

    genvar j;
    generate
        for (j = 0; j < uvs_pkg::DIV_STAGES; j++) begin : g_stage
            logic [uvs_pkg::DIV_NW-1:0] num_next;
            logic [uvs_pkg::DIV_NW-1:0] q_next;
            logic [uvs_pkg::DIV_RW-1:0] rem_next;
            logic [6:0]                 den_in;

            always_comb
            begin
                logic [uvs_pkg::DIV_NW-1:0] n;
                logic [uvs_pkg::DIV_NW-1:0] q;
                logic [uvs_pkg::DIV_RW-1:0] r;
                if (j == 0)
                begin
                    n      = num;
                    q      = '0;
                    r      = '0;
                    den_in = den;
                end
                else
                begin
                    n      = num_reg[(j == 0) ? 0 : j-1];
                    q      = q_reg[(j == 0) ? 0 : j-1];
                    r      = rem_reg[(j == 0) ? 0 : j-1];
                    den_in = den_reg[(j == 0) ? 0 : j-1];
                end
                for (int t = 0; t < uvs_pkg::DIV_PER; t++)
                begin
                    r = {r[uvs_pkg::DIV_RW-2:0], n[uvs_pkg::DIV_NW-1]};
                    n = {n[uvs_pkg::DIV_NW-2:0], 1'b0};
                    if (r >= {1'b0, den_in})
                    begin
                        r = r - {1'b0, den_in};
                        q = {q[uvs_pkg::DIV_NW-2:0], 1'b1};
                    end
                    else
                    begin
                        q = {q[uvs_pkg::DIV_NW-2:0], 1'b0};
                    end
                end
                num_next = n;
                q_next   = q;
                rem_next = r;
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    num_reg[j] <= num_next;
                    q_reg[j]   <= q_next;
                    rem_reg[j] <= rem_next;
                    den_reg[j] <= den_in;
                end
            end
        end
    endgenerate

    assign quo = q_reg[uvs_pkg::DIV_STAGES-1][15:0];

endmodule

// File: rtl/core/uvs_cordic.sv
// pipelined sine and cosine, 16 step cordic in phase units
module uvs_cordic (
    input  logic               clk,
    input  logic               en,
    input  logic [15:0]        phase,
    output logic signed [15:0] sn,
    output logic signed [15:0] cs
);

    logic signed [uvs_pkg::CX_W-1:0] x_reg [0:uvs_pkg::CORDIC_ITS];
    logic signed [uvs_pkg::CX_W-1:0] y_reg [0:uvs_pkg::CORDIC_ITS];
    logic signed [uvs_pkg::CZ_W-1:0] z_reg [0:uvs_pkg::CORDIC_ITS];
    logic                            neg_reg [0:uvs_pkg::CORDIC_ITS];
    logic signed [15:0]              sn_reg;
    logic signed [15:0]              cs_reg;

    function automatic logic signed [15:0] rnd_clamp(input logic signed [uvs_pkg::CX_W-1:0] v);
        logic signed [uvs_pkg::CX_W-1:0] r;
        logic signed [15:0]              o;
        if (v >= 0)
            r = (v + 27'sd512) >>> 10;
        else
            r = -((-v + 27'sd512) >>> 10);
        if (r > 27'sd16384)
            o = 16'sd16384;
        else if (r < -27'sd16384)
            o = -16'sd16384;
        else
            o = r[15:0];
        return o;
    endfunction

    // quadrant fold to +-90 degrees
    logic signed [uvs_pkg::CZ_W-1:0] z_in;
    logic signed [uvs_pkg::CZ_W-1:0] z_fold;
    logic                            neg_fold;

    always_comb
    begin
        z_in = uvs_pkg::CZ_W'($signed(phase));
        if (z_in > 18'sd16384)
        begin
            z_fold   = z_in - 18'sd32768;
            neg_fold = 1'b1;
        end
        else if (z_in < -18'sd16384)
        begin
            z_fold   = z_in + 18'sd32768;
            neg_fold = 1'b1;
        end
        else
        begin
            z_fold   = z_in;
            neg_fold = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]   <= uvs_pkg::CORDIC_K;
            y_reg[0]   <= '0;
            z_reg[0]   <= z_fold;
            neg_reg[0] <= neg_fold;
        end
    end

    genvar j;
    generate
        for (j = 1; j <= uvs_pkg::CORDIC_ITS; j++) begin : g_iter
            logic signed [uvs_pkg::CX_W-1:0] x_next;
            logic signed [uvs_pkg::CX_W-1:0] y_next;
            logic signed [uvs_pkg::CZ_W-1:0] z_next;

            always_comb
            begin
                logic signed [uvs_pkg::CX_W-1:0] xs;
                logic signed [uvs_pkg::CX_W-1:0] ys;
                logic signed [uvs_pkg::CX_W-1:0] dx;
                logic signed [uvs_pkg::CX_W-1:0] dy;
                logic signed [uvs_pkg::CZ_W-1:0] zs;
                xs = x_reg[j-1];
                ys = y_reg[j-1];
                zs = z_reg[j-1];
                for (int t = 0; t < uvs_pkg::CORDIC_PER; t++)
                begin
                    dx = ys >>> (uvs_pkg::CORDIC_PER * (j - 1) + t);
                    dy = xs >>> (uvs_pkg::CORDIC_PER * (j - 1) + t);
                    if (zs >= 0)
                    begin
                        xs = xs - dx;
                        ys = ys + dy;
                        zs = zs - uvs_pkg::atan_phase(uvs_pkg::CORDIC_PER * (j - 1) + t);
                    end
                    else
                    begin
                        xs = xs + dx;
                        ys = ys - dy;
                        zs = zs + uvs_pkg::atan_phase(uvs_pkg::CORDIC_PER * (j - 1) + t);
                    end
                end
                x_next = xs;
                y_next = ys;
                z_next = zs;
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    x_reg[j]   <= x_next;
                    y_reg[j]   <= y_next;
                    z_reg[j]   <= z_next;
                    neg_reg[j] <= neg_reg[j-1];
                end
            end
        end
    endgenerate

    // undo the fold, round to q1.14 and clamp
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (neg_reg[uvs_pkg::CORDIC_ITS])
            begin
                cs_reg <= rnd_clamp(-x_reg[uvs_pkg::CORDIC_ITS]);
                sn_reg <= rnd_clamp(-y_reg[uvs_pkg::CORDIC_ITS]);
            end
            else
            begin
                cs_reg <= rnd_clamp(x_reg[uvs_pkg::CORDIC_ITS]);
                sn_reg <= rnd_clamp(y_reg[uvs_pkg::CORDIC_ITS]);
            end
        end
    end

    assign sn = sn_reg;
    assign cs = cs_reg;

endmodule

// File: rtl/core/uv_sphere_vertex_index_generator_unit.sv
// uv sphere vertex generator: an accepted grid point reaches its first result through
// fifteen pipeline stages (input, 6 divider, 6 cordic, 2 multiply) and one result register
// a grid point may enter every cycle unless in_stall is raised; the shared result
// channel gives 4 results per inner point, 2 per edge point and 1 per error
// reset (async, active low) empties the pipeline and loads radius 1.0 and 16 rings/sectors
module uv_sphere_vertex_index_generator_unit #(
    parameter int MAX_RINGS   = 64,
    parameter int MAX_SECTORS = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [5:0]         ring,
    input  logic [5:0]         sector,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [1:0]         kind,
    output logic signed [16:0] comp_a,
    output logic signed [16:0] comp_b,
    output logic signed [16:0] comp_c,
    output logic [15:0]        tex_u,
    output logic [15:0]        tex_v,
    output logic               last
);

    localparam int LS = uvs_pkg::LAST_STAGE;

    // configuration registers, always ready
    logic [15:0] radius_reg;
    logic [6:0]  ring_count_reg;
    logic [6:0]  sector_count_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg       <= 16'd256;
            ring_count_reg   <= 7'd16;
            sector_count_reg <= 7'd16;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                uvs_pkg::REG_RADIUS:  radius_reg       <= cfg_data;
                uvs_pkg::REG_RINGS:   ring_count_reg   <= cfg_data[6:0];
                uvs_pkg::REG_SECTORS: sector_count_reg <= cfg_data[6:0];
                default: ;
            endcase
        end
    end

    logic       cfg_bad;
    logic [6:0] rd;
    logic [6:0] sd;

    assign cfg_bad = (ring_count_reg < 7'd2) || (int'(ring_count_reg) > MAX_RINGS) ||
                     (sector_count_reg < 7'd2) || (int'(sector_count_reg) > MAX_SECTORS);
    assign rd = ring_count_reg - 7'd1;
    assign sd = sector_count_reg - 7'd1;

    // global advance: the whole pipeline moves when its tail can drain
    logic en;
    logic load;
    logic load_ok;
    logic xfer;
    logic res_last;
    logic ser_vld_reg;
    logic [1:0] ser_idx_reg;

    logic          vld_reg  [0:LS];
    uvs_pkg::side_t side_reg [0:LS];
    logic [5:0]    r0_reg;
    logic [5:0]    s0_reg;

    assign xfer     = ser_vld_reg && !out_stall;
    assign load_ok  = !ser_vld_reg || (xfer && res_last);
    assign en       = !vld_reg[LS] || load_ok;
    assign load     = vld_reg[LS] && load_ok;
    assign in_stall = !en;

    // stage 0: range checks and the cell's base vertex index
    uvs_pkg::side_t side0;
    always_comb
    begin
        side0.err      = cfg_bad || ({1'b0, ring} >= ring_count_reg) ||
                         ({1'b0, sector} >= sector_count_reg);
        side0.has_quad = ({1'b0, ring} < rd) && ({1'b0, sector} < sd);
        side0.i00      = 14'(ring) * 14'(sector_count_reg) + 14'(sector);
        side0.tu       = '0;
        side0.tv       = '0;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= side0;
            r0_reg      <= ring;
            s0_reg      <= sector;
        end
    end

    // valid bits travel with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= LS; k++)
                vld_reg[k] <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0] <= in_valid;
            for (int k = 1; k <= LS; k++)
                vld_reg[k] <= vld_reg[k-1];
        end
    end

    // three rounded ratios: theta phase (also tex v), phi phase, tex u
    logic [15:0] q_tv;
    logic [15:0] q_phi;
    logic [15:0] q_tu;

    uvs_div u_div_tv (
        .clk (clk),
        .en  (en),
        .num ((uvs_pkg::DIV_NW'(r0_reg) << 15) + uvs_pkg::DIV_NW'(rd >> 1)),
        .den (rd),
        .quo (q_tv)
    );

    uvs_div u_div_phi (
        .clk (clk),
        .en  (en),
        .num ((uvs_pkg::DIV_NW'(s0_reg) << 16) + uvs_pkg::DIV_NW'(sd >> 1)),
        .den (sd),
        .quo (q_phi)
    );

    uvs_div u_div_tu (
        .clk (clk),
        .en  (en),
        .num ((uvs_pkg::DIV_NW'(s0_reg) << 15) + uvs_pkg::DIV_NW'(sd >> 1)),
        .den (sd),
        .quo (q_tu)
    );

    // sideband follows the item; texture coordinates join after the dividers
    genvar g;
    generate
        for (g = 1; g <= LS; g++) begin : g_side
            uvs_pkg::side_t side_next;

            always_comb
            begin
                side_next = side_reg[g-1];
                if (g == uvs_pkg::DIV_OUT_STAGE + 1)
                begin
                    side_next.tu = q_tu;
                    side_next.tv = q_tv;
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                    side_reg[g] <= side_next;
            end
        end
    endgenerate

    logic signed [15:0] st;
    logic signed [15:0] ct;
    logic signed [15:0] sp;
    logic signed [15:0] cp;

    uvs_cordic u_cordic_theta (
        .clk   (clk),
        .en    (en),
        .phase (q_tv),
        .sn    (st),
        .cs    (ct)
    );

    uvs_cordic u_cordic_phi (
        .clk   (clk),
        .en    (en),
        .phase (q_phi),
        .sn    (sp),
        .cs    (cp)
    );

    // unit direction from the two angle pairs
    logic signed [16:0] ux_reg, uy_reg, uz_reg;
    logic signed [33:0] ux_full, uz_full;

    assign ux_full = uvs_pkg::rnd14(34'(cp * st));
    assign uz_full = uvs_pkg::rnd14(34'(sp * st));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ux_reg <= ux_full[16:0];
            uy_reg <= -17'(ct);
            uz_reg <= uz_full[16:0];
        end
    end

    // position: unit direction times radius, clamped to q8.8
    function automatic logic signed [16:0] pos_q88(input logic signed [16:0] u,
                                                   input logic [15:0] rad);
        logic signed [33:0] p;
        logic signed [16:0] o;
        p = uvs_pkg::rnd14(34'(u) * $signed({18'd0, rad}));
        if (p > 34'sd65535)
            o = 17'sd65535;
        else if (p < -34'sd65536)
            o = -17'sd65536;
        else
            o = p[16:0];
        return o;
    endfunction

    logic signed [16:0] px_reg, py_reg, pz_reg;
    logic signed [16:0] nx_reg, ny_reg, nz_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            px_reg <= pos_q88(ux_reg, radius_reg);
            py_reg <= pos_q88(uy_reg, radius_reg);
            pz_reg <= pos_q88(uz_reg, radius_reg);
            nx_reg <= ux_reg;
            ny_reg <= uy_reg;
            nz_reg <= uz_reg;
        end
    end

    // result register: walks through the results of one grid point
    uvs_pkg::side_t     ser_side_reg;
    logic signed [16:0] sp_x_reg, sp_y_reg, sp_z_reg;
    logic signed [16:0] sn_x_reg, sn_y_reg, sn_z_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ser_vld_reg <= 1'b0;
            ser_idx_reg <= 2'd0;
        end
        else if (load)
        begin
            ser_vld_reg <= 1'b1;
            ser_idx_reg <= 2'd0;
        end
        else if (xfer)
        begin
            if (res_last)
                ser_vld_reg <= 1'b0;
            else
                ser_idx_reg <= ser_idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            ser_side_reg <= side_reg[LS];
            sp_x_reg     <= px_reg;
            sp_y_reg     <= py_reg;
            sp_z_reg     <= pz_reg;
            sn_x_reg     <= nx_reg;
            sn_y_reg     <= ny_reg;
            sn_z_reg     <= nz_reg;
        end
    end

    assign res_last = ser_side_reg.err || ser_idx_reg == 2'd3 ||
                      (ser_idx_reg == 2'd1 && !ser_side_reg.has_quad);

    logic signed [16:0] i00, i01, i10, i11;
    assign i00 = 17'(ser_side_reg.i00);
    assign i01 = i00 + 17'sd1;
    assign i10 = i00 + 17'(sector_count_reg);
    assign i11 = i10 + 17'sd1;

    always_comb
    begin
        kind   = uvs_pkg::KIND_ERR;
        comp_a = '0;
        comp_b = '0;
        comp_c = '0;
        tex_u  = '0;
        tex_v  = '0;
        last   = res_last;
        if (!ser_side_reg.err)
        begin
            unique case (ser_idx_reg)
                2'd0:
                begin
                    kind   = uvs_pkg::KIND_POS;
                    comp_a = sp_x_reg;
                    comp_b = sp_y_reg;
                    comp_c = sp_z_reg;
                end
                2'd1:
                begin
                    kind   = uvs_pkg::KIND_NRM;
                    comp_a = sn_x_reg;
                    comp_b = sn_y_reg;
                    comp_c = sn_z_reg;
                    tex_u  = ser_side_reg.tu;
                    tex_v  = ser_side_reg.tv;
                end
                2'd2:
                begin
                    kind   = uvs_pkg::KIND_TRI;
                    comp_a = i00;
                    comp_b = i11;
                    comp_c = i01;
                end
                default:
                begin
                    kind   = uvs_pkg::KIND_TRI;
                    comp_a = i00;
                    comp_b = i10;
                    comp_c = i11;
                end
            endcase
        end
    end

    assign out_valid = ser_vld_reg;

    // an error point gives exactly one result
    a_err_single: assert property (@(posedge clk) disable iff (!rst_n)
        ser_vld_reg && ser_side_reg.err |-> ser_idx_reg == 2'd0)
        else $error("error point past its first result");

    // a non-final transfer steps to the next result of the same point
    a_step: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last |=>
            out_valid && ser_idx_reg == 2'($past(ser_idx_reg) + 2'd1))
        else $error("result sequence skipped or lost");

    // a point ends on its triangle pair unless it has no cell or is in error
    a_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last |->
            (kind == uvs_pkg::KIND_ERR || kind == uvs_pkg::KIND_TRI ||
             (kind == uvs_pkg::KIND_NRM && !ser_side_reg.has_quad)))
        else $error("wrong final result kind");

    // the final transfer with nothing waiting empties the result register
    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && last && !vld_reg[LS] |=> !out_valid)
        else $error("result repeated after final transfer");

endmodule

// File: tb/uv_sphere_vertex_index_generator_unit_test.sv
// self-checking testbench for the uv sphere vertex and index generator
module uv_sphere_vertex_index_generator_unit_test;

    // allowed grid sizes and the cycle limit of the whole run
    localparam int  RING_MAX   = 64;
    localparam int  SECTOR_MAX = 64;
    localparam int  DRAIN_WAIT = 24;
    localparam longint CYCLE_LIMIT = 400000;

    typedef struct {
        logic [1:0]         kind;
        logic signed [16:0] a;
        logic signed [16:0] b;
        logic signed [16:0] c;
        logic [15:0]        u;
        logic [15:0]        v;
        logic               last;
    } vertex_result_t;

    // scoreboard: keeps its own copy of the registers and the results still owed
    class vertex_scoreboard;
        vertex_result_t owed[$];
        longint radius_q88;
        longint rings;
        longint sectors;
        int     failures;
        int     seen;
        int     cells;
        int     errors_seen;
        longint atan_step[16] = '{8192, 4836, 2555, 1297, 651, 326, 163, 81,
                                  41, 20, 10, 5, 3, 1, 1, 0};

        function new();
            radius_q88 = 256;
            rings      = 16;
            sectors    = 16;
        endfunction

        function void write_reg(logic [1:0] idx, logic [15:0] data);
            if (idx == uvs_pkg::REG_RADIUS)
                radius_q88 = data;
            else if (idx == uvs_pkg::REG_RINGS)
                rings = data[6:0];
            else if (idx == uvs_pkg::REG_SECTORS)
                sectors = data[6:0];
        endfunction

        function longint round_drop(longint v, int n);
            longint h;
            h = longint'(1) << (n - 1);
            return (v >= 0) ? ((v + h) >>> n) : -((-v + h) >>> n);
        endfunction

        function longint clip(longint v, longint lo, longint hi);
            return (v < lo) ? lo : ((v > hi) ? hi : v);
        endfunction

        function longint div_round(longint num, longint den);
            return (num + den / 2) / den;
        endfunction

        // 16 step cordic, q24 vector, phase of 2^16 per turn
        function void sin_cos(longint phase, output longint sn, output longint cs);
            longint x, y, z, dx, dy;
            bit     flip;
            x    = 10188014;
            y    = 0;
            flip = 0;
            z    = phase & 16'hffff;
            if (z >= 32768) z -= 65536;
            if (z > 16384)
            begin
                z -= 32768;
                flip = 1;
            end
            else if (z < -16384)
            begin
                z += 32768;
                flip = 1;
            end
            for (int i = 0; i < 16; i++)
            begin
                dx = y >>> i;
                dy = x >>> i;
                if (z >= 0)
                begin
                    x -= dx;
                    y += dy;
                    z -= atan_step[i];
                end
                else
                begin
                    x += dx;
                    y -= dy;
                    z += atan_step[i];
                end
            end
            if (flip)
            begin
                x = -x;
                y = -y;
            end
            cs = clip(round_drop(x, 10), -16384, 16384);
            sn = clip(round_drop(y, 10), -16384, 16384);
        endfunction

        function void push(logic [1:0] k, longint a, longint b, longint c,
                           longint u, longint v, bit lst);
            vertex_result_t e;
            e.kind = k; e.a = a[16:0]; e.b = b[16:0]; e.c = c[16:0];
            e.u = u[15:0]; e.v = v[15:0]; e.last = lst;
            owed = {owed, e};
        endfunction

        // works out every result that an accepted grid point owes
        function void note_point(logic [5:0] r, logic [5:0] s);
            longint st, ct, sp, cp, ux, uy, uz, rd, sd, i00;
            bit     inner;
            if (rings < 2 || rings > RING_MAX || sectors < 2 || sectors > SECTOR_MAX ||
                r >= rings || s >= sectors)
            begin
                push(uvs_pkg::KIND_ERR, 0, 0, 0, 0, 0, 1);
                errors_seen++;
                return;
            end
            rd = rings - 1;
            sd = sectors - 1;
            sin_cos(div_round(longint'(r) * 32768, rd), st, ct);
            sin_cos(div_round(longint'(s) * 65536, sd), sp, cp);
            ux = round_drop(cp * st, 14);
            uy = -ct;
            uz = round_drop(sp * st, 14);
            inner = (r < rd) && (s < sd);
            push(uvs_pkg::KIND_POS, clip(round_drop(ux * radius_q88, 14), -65536, 65535),
                 clip(round_drop(uy * radius_q88, 14), -65536, 65535),
                 clip(round_drop(uz * radius_q88, 14), -65536, 65535), 0, 0, 0);
            push(uvs_pkg::KIND_NRM, ux, uy, uz, div_round(longint'(s) * 32768, sd),
                 div_round(longint'(r) * 32768, rd), !inner);
            if (!inner) return;
            cells++;
            i00 = longint'(r) * sectors + s;
            push(uvs_pkg::KIND_TRI, i00, i00 + sectors + 1, i00 + 1, 0, 0, 0);
            push(uvs_pkg::KIND_TRI, i00, i00 + sectors, i00 + sectors + 1, 0, 0, 1);
        endfunction

        task report(string msg);
            $display("mismatch at result %0d: %s", seen, msg);
            failures++;
        endtask

        task compare(string what, longint got, longint want);
            if (got != want)
                report($sformatf("%s got %0d expected %0d", what, got, want));
        endtask

        task check_result(vertex_result_t got);
            vertex_result_t e;
            seen++;
            if (owed.size() == 0)
            begin
                report("result with nothing owed");
                return;
            end
            e = owed.pop_front();
            if (got.kind !== e.kind) compare("kind", got.kind, e.kind);
            if (got.a !== e.a)       compare("comp_a", got.a, e.a);
            if (got.b !== e.b)       compare("comp_b", got.b, e.b);
            if (got.c !== e.c)       compare("comp_c", got.c, e.c);
            if (got.u !== e.u)       compare("tex_u", got.u, e.u);
            if (got.v !== e.v)       compare("tex_v", got.v, e.v);
            if (got.last !== e.last) compare("last", got.last, e.last);
        endtask
    endclass

    logic               clk = 0;
    logic               rst_n = 0;
    logic               cfg_valid = 0;
    logic               cfg_ready;
    logic [1:0]         cfg_index = uvs_pkg::REG_RADIUS;
    logic [15:0]        cfg_data = 0;
    logic               in_valid = 0;
    logic               in_stall;
    logic [5:0]         ring = 0;
    logic [5:0]         sector = 0;
    logic               out_valid;
    logic               out_stall = 0;
    logic [1:0]         kind;
    logic signed [16:0] comp_a, comp_b, comp_c;
    logic [15:0]        tex_u, tex_v;
    logic               last;

    vertex_scoreboard sb = new();
    bit     calm = 0;      // when set neither side idles
    longint cycles = 0;
    int     points = 0;

    uv_sphere_vertex_index_generator_unit dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall), .ring(ring), .sector(sector),
        .out_valid(out_valid), .out_stall(out_stall), .kind(kind),
        .comp_a(comp_a), .comp_b(comp_b), .comp_c(comp_c),
        .tex_u(tex_u), .tex_v(tex_v), .last(last)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // the receiving side stalls at random except during the calm stretch
    always @(negedge clk)
    begin
        out_stall <= !calm && ($urandom_range(99) < 34);
    end

    // result transfers are checked at the rising edge
    always @(posedge clk)
    begin
        vertex_result_t got;
        if (rst_n && out_valid && !out_stall)
        begin
            got.kind = kind; got.a = comp_a; got.b = comp_b; got.c = comp_c;
            got.u = tex_u; got.v = tex_v; got.last = last;
            sb.check_result(got);
        end
    end

    // watchdog on the whole run
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("Test completed with failures");
            $finish;
        end
    end

    // one grid point transfer; entered and left just after a falling edge
    task automatic send_point(logic [5:0] r, logic [5:0] s);
        while (!calm && $urandom_range(99) < 34)
        begin
            in_valid <= 0;
            @(negedge clk);
        end
        in_valid <= 1;
        ring     <= r;
        sector   <= s;
        do @(posedge clk); while (in_stall);
        sb.note_point(r, s);
        points++;
        @(negedge clk);
    endtask

    // lets every owed result arrive, then the pipeline latency on top
    task automatic drain();
        in_valid <= 0;
        while (sb.owed.size() != 0) @(negedge clk);
        repeat (DRAIN_WAIT) @(negedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] data);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        sb.write_reg(idx, data);
        @(negedge clk);
        cfg_valid <= 0;
        @(negedge clk);
    endtask

    task automatic set_shape(logic [15:0] rad, logic [15:0] nr, logic [15:0] ns);
        drain();
        write_reg(uvs_pkg::REG_RADIUS, rad);
        write_reg(uvs_pkg::REG_RINGS, nr);
        write_reg(uvs_pkg::REG_SECTORS, ns);
    endtask

    // random grid points, most inside the grid, the rest anywhere
    task automatic random_points(int n);
        int nr, ns;
        for (int i = 0; i < n; i++)
        begin
            nr = sb.rings;
            ns = sb.sectors;
            if (nr >= 2 && nr <= RING_MAX && ns >= 2 && ns <= SECTOR_MAX &&
                $urandom_range(99) < 82)
                send_point($urandom_range(nr - 1), $urandom_range(ns - 1));
            else
                send_point($urandom_range(63), $urandom_range(63));
        end
    endtask

    initial
    begin
        repeat (6) @(negedge clk);
        rst_n <= 1;
        @(negedge clk);

        // reset shape: poles, seam, last ring and sector, outside the grid
        send_point(0, 0);
        send_point(0, 14);
        send_point(15, 0);
        send_point(14, 14);
        send_point(15, 15);
        send_point(7, 3);
        send_point(16, 0);
        send_point(0, 16);
        send_point(63, 63);

        // smallest grid with the largest radius, clamp of the position
        set_shape(16'hffff, 2, 2);
        send_point(0, 0);
        send_point(1, 0);
        send_point(0, 1);
        send_point(1, 1);
        send_point(2, 1);

        // largest grid, zero radius
        set_shape(0, 64, 64);
        send_point(0, 0);
        send_point(63, 63);
        send_point(62, 62);
        send_point(32, 16);

        // ring and sector counts out of the allowed range, upper bits dropped
        set_shape(256, 1, 16);
        send_point(0, 0);
        set_shape(256, 16, 65);
        send_point(0, 0);
        set_shape(256, 16'hff80, 127);
        send_point(0, 0);

        // an index past the register list changes nothing
        drain();
        write_reg(2'd3, 16'h5a5a);
        send_point(3, 3);

        set_shape(16'h0180, 16, 16);
        random_points(60);
        set_shape($urandom, $urandom_range(64, 2), $urandom_range(64, 2));
        calm = 1;
        random_points(60);
        calm = 0;
        set_shape($urandom, 64, 64);
        random_points(60);
        set_shape(16'hffff, $urandom_range(8, 2), $urandom_range(8, 2));
        random_points(60);
        set_shape($urandom, $urandom_range(127), $urandom_range(127));
        random_points(30);
        set_shape($urandom, $urandom_range(64, 2), $urandom_range(64, 2));
        drain();
        write_reg(2'd3, $urandom);
        random_points(90);

        drain();
        $display("%0d grid points sent over several shapes, %0d results checked", points,
                 sb.seen);
        $display("%0d full grid cells and %0d error results among them", sb.cells,
                 sb.errors_seen);
        if (sb.failures == 0 && sb.owed.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// File: filelist.f
rtl/core/uvs_pkg.sv
rtl/core/uvs_div.sv
rtl/core/uvs_cordic.sv
rtl/core/uv_sphere_vertex_index_generator_unit.sv
tb/uv_sphere_vertex_index_generator_unit_test.sv
